// ===== hw/rtl/wtcsb_pkg.sv =====
package wtcsb_pkg;

    localparam int WORD_BYTES = 8;
    localparam int BEAT_SHIFT = 3;

    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_FILL  = 2'd2;
    localparam logic [1:0] ACT_DRAIN = 2'd3;

    localparam logic [1:0] BT_FIXED = 2'd0;
    localparam logic [1:0] BT_INCR  = 2'd1;
    localparam logic [1:0] BT_WRAP  = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] base_address;
        logic [7:0]  beat_index;
        logic [8:0]  beat_count;
        logic [1:0]  burst_type;
        logic [63:0] write_data;
        logic        fill_last;
    } req_t;

    typedef struct packed {
        logic [31:0] beat_address;
        logic        hit;
        logic        read_valid;
        logic [63:0] read_data;
        logic        fetch_request;
        logic [31:0] fetch_address;
        logic        write_accepted;
        logic        drain_valid;
        logic [31:0] drain_address;
        logic [63:0] drain_data;
    } rsp_t;

endpackage

// ===== hw/rtl/wtcsb_ram.sv =====
module wtcsb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/write_through_cache_store_buffer.sv =====
// Direct-mapped write-through cache (no write allocate) with a ring store
// buffer that keeps one slot free. Each transaction passes through these steps
// before the next is accepted: tag and data memory read, read-modify-write of the
// memories and buffer pointers, store buffer read at the head, and loading of
// the result register. A result waiting in the output register does not block
// the next transaction until that one reaches its final step. After reset the
// tag memory is cleared one line per cycle, so no transaction is accepted until
// all LINES lines have been cleared.
module write_through_cache_store_buffer
    import wtcsb_pkg::*;
#(
    parameter int LINES        = 64,
    parameter int BLOCK_BYTES  = 64,
    parameter int BUFFER_DEPTH = 8
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int WPL        = BLOCK_BYTES / WORD_BYTES;
    localparam int OFF_BITS   = $clog2(BLOCK_BYTES);
    localparam int LIDX_BITS  = $clog2(LINES);
    localparam int TAG_W      = 32 - OFF_BITS - LIDX_BITS;
    localparam int WORD_BITS  = $clog2(WPL);
    localparam int WW         = (WORD_BITS > 0) ? WORD_BITS : 1;
    localparam int DEPTH_D    = LINES * WPL;
    localparam int DA_W       = $clog2(DEPTH_D);
    localparam int PTR_W      = $clog2(BUFFER_DEPTH);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_BUF,
        S_RESP
    } state_t;

    function automatic logic [31:0] beat_addr_of(input req_t r);
        logic [31:0] incr;
        logic [31:0] mask;
        logic        pow2;
        incr = r.base_address + {21'b0, r.beat_index, 3'b0};
        mask = {20'b0, r.beat_count, 3'b0} - 32'd1;
        pow2 = (r.beat_count != 9'd0) && ((r.beat_count & (r.beat_count - 9'd1)) == 9'd0);
        case (r.burst_type)
            BT_FIXED: beat_addr_of = r.base_address;
            BT_WRAP:  beat_addr_of = pow2 ? ((r.base_address & ~mask) | (incr & mask)) : incr;
            default:  beat_addr_of = incr;
        endcase
    endfunction

    function automatic logic [LIDX_BITS-1:0] line_of(input logic [31:0] a);
        line_of = LIDX_BITS'(a >> OFF_BITS);
    endfunction

    function automatic logic [TAG_W-1:0] tag_of(input logic [31:0] a);
        tag_of = TAG_W'(a >> (OFF_BITS + LIDX_BITS));
    endfunction

    function automatic logic [WW-1:0] word_of(input logic [31:0] a);
        word_of = WW'((a >> BEAT_SHIFT) & 32'(WPL - 1));
    endfunction

    function automatic logic [DA_W-1:0] daddr_of(input logic [LIDX_BITS-1:0] l,
                                                 input logic [WW-1:0] w);
        daddr_of = (DA_W'(l) << WORD_BITS) | DA_W'(w);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    state_t               state_reg, state_next;
    logic [LIDX_BITS-1:0] clr_reg, clr_next;
    logic [PTR_W-1:0]     head_reg, head_next;
    logic [PTR_W-1:0]     tail_reg, tail_next;
    req_t                 item_reg, item_next;
    logic [31:0]          addr_reg, addr_next;
    rsp_t                 res_reg, res_next;
    rsp_t                 rsp_reg, rsp_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    logic [31:0]          req_incr;
    logic [31:0]          req_addr;
    logic                 accept;

    logic                 tag_we, tag_re;
    logic [LIDX_BITS-1:0] tag_waddr;
    logic [TAG_W:0]       tag_wdata, tag_rd;
    logic                 data_we, data_re;
    logic [DA_W-1:0]      data_waddr;
    logic [63:0]          data_rd;
    logic                 buf_we, buf_re;
    logic [95:0]          buf_rd;

    logic [LIDX_BITS-1:0] look_line, fill_line;
    logic [WW-1:0]        look_word, fill_word;
    logic                 hit_raw, buf_full, buf_empty, fill_in_range;
    logic [PTR_W-1:0]     tail_inc;

    assign req_incr = req.base_address + {21'b0, req.beat_index, 3'b0};
    assign req_addr = (req.action == ACT_FILL) ? req_incr : beat_addr_of(req);
    assign req_stall = (state_reg != S_IDLE);
    assign accept = req_valid && !req_stall;

    assign look_line = line_of(addr_reg);
    assign look_word = word_of(addr_reg);
    assign fill_line = line_of(item_reg.base_address);
    assign fill_word = WW'(32'(item_reg.beat_index) & 32'(WPL - 1));
    assign fill_in_range = (32'(item_reg.beat_index) < 32'(WPL));
    assign hit_raw = tag_rd[TAG_W] && (tag_rd[TAG_W-1:0] == tag_of(addr_reg));
    assign tail_inc = ptr_inc(tail_reg);
    assign buf_full = (tail_inc == head_reg);
    assign buf_empty = (head_reg == tail_reg);

    wtcsb_ram #(.WIDTH(TAG_W + 1), .DEPTH(LINES)) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .re    (tag_re),
        .raddr (line_of(req_addr)),
        .rdata (tag_rd)
    );

    wtcsb_ram #(.WIDTH(64), .DEPTH(DEPTH_D)) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (item_reg.write_data),
        .re    (data_re),
        .raddr (daddr_of(line_of(req_addr), word_of(req_addr))),
        .rdata (data_rd)
    );

    wtcsb_ram #(.WIDTH(96), .DEPTH(BUFFER_DEPTH)) u_buf_ram (
        .clk   (clk),
        .we    (buf_we),
        .waddr (tail_reg),
        .wdata ({addr_reg, item_reg.write_data}),
        .re    (buf_re),
        .raddr (head_reg),
        .rdata (buf_rd)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        item_next      = item_reg;
        addr_next      = addr_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        tag_we         = 1'b0;
        tag_re         = 1'b0;
        tag_waddr      = fill_line;
        tag_wdata      = {1'b1, tag_of(item_reg.base_address)};
        data_we        = 1'b0;
        data_re        = 1'b0;
        data_waddr     = daddr_of(look_line, look_word);
        buf_we         = 1'b0;
        buf_re         = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                tag_we    = 1'b1;
                tag_waddr = clr_reg;
                tag_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LIDX_BITS'(LINES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    tag_re     = 1'b1;
                    data_re    = 1'b1;
                    item_next  = req;
                    addr_next  = req_addr;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                res_next = '0;
                res_next.beat_address = addr_reg;
                case (item_reg.action)
                    ACT_READ:
                    begin
                        res_next.hit           = hit_raw;
                        res_next.read_valid    = hit_raw;
                        res_next.read_data     = hit_raw ? data_rd : 64'd0;
                        res_next.fetch_request = !hit_raw;
                        res_next.fetch_address = hit_raw ? 32'd0
                                               : (addr_reg & ~32'(BLOCK_BYTES - 1));
                    end
                    ACT_WRITE:
                    begin
                        if (!buf_full)
                        begin
                            buf_we                  = 1'b1;
                            tail_next               = tail_inc;
                            res_next.write_accepted = 1'b1;
                            res_next.hit            = hit_raw;
                            data_we                 = hit_raw;
                        end
                    end
                    ACT_FILL:
                    begin
                        data_we    = fill_in_range;
                        data_waddr = daddr_of(fill_line, fill_word);
                        tag_we     = item_reg.fill_last;
                    end
                    default:
                    begin
                        res_next.beat_address = 32'd0;
                        if (!buf_empty)
                        begin
                            head_next = ptr_inc(head_reg);
                        end
                    end
                endcase
                state_next = S_BUF;
            end
            S_BUF:
            begin
                buf_re     = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next               = res_reg;
                    rsp_next.drain_valid   = !buf_empty;
                    rsp_next.drain_address = buf_empty ? 32'd0 : buf_rd[95:64];
                    rsp_next.drain_data    = buf_empty ? 64'd0 : buf_rd[63:0];
                    rsp_valid_next         = 1'b1;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            item_reg      <= '0;
            addr_reg      <= '0;
            res_reg       <= '0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            item_reg      <= item_next;
            addr_reg      <= addr_next;
            res_reg       <= res_next;
            rsp_reg       <= rsp_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

`ifndef SYNTHESIS
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg <= PTR_W'(BUFFER_DEPTH - 1)) && (tail_reg <= PTR_W'(BUFFER_DEPTH - 1)))
        else $error("store buffer pointer out of range");

    a_write_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOK && item_reg.action == ACT_WRITE && !buf_full)
        |=> (tail_reg != head_reg))
        else $error("accepted write left the store buffer empty");

    a_drain_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOK && item_reg.action == ACT_DRAIN && !buf_empty)
        |=> (head_reg != $past(head_reg)))
        else $error("drain done did not retire the head entry");

    a_tag_rw: assert property (@(posedge clk) disable iff (!rst_n)
        tag_re |-> (!tag_we && !data_we))
        else $error("tag or data memory read and written in the same cycle");
`endif

endmodule

// ===== sim/wtcsb_check.sv =====
`timescale 1ns / 1ps

module wtcsb_check
    import wtcsb_pkg::*;
#(
    parameter int LINES        = 64,
    parameter int BLOCK_BYTES  = 64,
    parameter int BUFFER_DEPTH = 8
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_stall,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_stall,
    input  rsp_t rsp,
    output int   errors,
    output int   pending
);

    localparam int OFFSET_W = $clog2(BLOCK_BYTES);
    localparam int INDEX_W  = $clog2(LINES);
    localparam int TAG_W    = 32 - OFFSET_W - INDEX_W;
    localparam int WORDS    = BLOCK_BYTES / WORD_BYTES;

    logic             line_ok   [LINES];
    logic [TAG_W-1:0] line_tag  [LINES];
    logic [63:0]      line_word [LINES * WORDS];
    logic [31:0]      sb_addr   [BUFFER_DEPTH];
    logic [63:0]      sb_data   [BUFFER_DEPTH];
    int               sb_head;
    int               sb_tail;
    rsp_t             due_rsp   [$];
    rsp_t             want;

    function automatic logic [31:0] beat_address_of(req_t t);
        logic [31:0] inc;
        logic [31:0] mask;
        inc = t.base_address + (32'(t.beat_index) << BEAT_SHIFT);
        if (t.burst_type == BT_FIXED)
            return t.base_address;
        // wrap only for power-of-two counts, everything else increments
        if (t.burst_type == BT_WRAP && t.beat_count != 0 &&
            (t.beat_count & (t.beat_count - 1)) == 0)
        begin
            mask = (32'(t.beat_count) << BEAT_SHIFT) - 1;
            return (t.base_address & ~mask) | (inc & mask);
        end
        return inc;
    endfunction

    function automatic logic line_hit(logic [31:0] a);
        return line_ok[a[OFFSET_W +: INDEX_W]] &&
               line_tag[a[OFFSET_W +: INDEX_W]] == a[31 -: TAG_W];
    endfunction

    function automatic int word_slot(logic [31:0] a);
        return int'(a[OFFSET_W +: INDEX_W]) * WORDS + int'(a[OFFSET_W-1:0] >> BEAT_SHIFT);
    endfunction

    function automatic rsp_t access_cache(req_t t);
        rsp_t        o;
        logic [31:0] a;
        int          li;
        int          nxt;
        o = '0;
        a = beat_address_of(t);
        case (t.action)
            ACT_READ:
            begin
                o.beat_address = a;
                if (line_hit(a))
                begin
                    o.hit        = 1'b1;
                    o.read_valid = 1'b1;
                    o.read_data  = line_word[word_slot(a)];
                end
                else
                begin
                    o.fetch_request = 1'b1;
                    o.fetch_address = a & ~32'(BLOCK_BYTES - 1);
                end
            end
            ACT_WRITE:
            begin
                o.beat_address = a;
                nxt = (sb_tail + 1) % BUFFER_DEPTH;
                if (nxt != sb_head)
                begin
                    sb_addr[sb_tail] = a;
                    sb_data[sb_tail] = t.write_data;
                    sb_tail = nxt;
                    o.write_accepted = 1'b1;
                    if (line_hit(a))
                    begin
                        o.hit = 1'b1;
                        line_word[word_slot(a)] = t.write_data;
                    end
                end
            end
            ACT_FILL:
            begin
                li = int'(t.base_address[OFFSET_W +: INDEX_W]);
                o.beat_address = t.base_address + (32'(t.beat_index) << BEAT_SHIFT);
                if (t.beat_index < WORDS)
                    line_word[li * WORDS + int'(t.beat_index)] = t.write_data;
                if (t.fill_last)
                begin
                    line_ok[li]  = 1'b1;
                    line_tag[li] = t.base_address[31 -: TAG_W];
                end
            end
            ACT_DRAIN:
            begin
                if (sb_head != sb_tail)
                    sb_head = (sb_head + 1) % BUFFER_DEPTH;
            end
        endcase
        if (sb_head != sb_tail)
        begin
            o.drain_valid   = 1'b1;
            o.drain_address = sb_addr[sb_head];
            o.drain_data    = sb_data[sb_head];
        end
        return o;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] exp_val,
                                 input logic [63:0] got);
        if (got !== exp_val)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_val, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LINES; i++)
            begin
                line_ok[i]  = 1'b0;
                line_tag[i] = '0;
            end
            sb_head = 0;
            sb_tail = 0;
            due_rsp.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (due_rsp.size() == 0)
                begin
                    errors++;
                    $display("%0t: response with no transaction outstanding, expected none, got %h",
                             $time, rsp);
                end
                else
                begin
                    want = due_rsp[0];
                    due_rsp.delete(0);
                    compare_field("beat_address", want.beat_address, rsp.beat_address);
                    compare_field("hit", want.hit, rsp.hit);
                    compare_field("read_valid", want.read_valid, rsp.read_valid);
                    compare_field("read_data", want.read_data, rsp.read_data);
                    compare_field("fetch_request", want.fetch_request, rsp.fetch_request);
                    compare_field("fetch_address", want.fetch_address, rsp.fetch_address);
                    compare_field("write_accepted", want.write_accepted, rsp.write_accepted);
                    compare_field("drain_valid", want.drain_valid, rsp.drain_valid);
                    compare_field("drain_address", want.drain_address, rsp.drain_address);
                    compare_field("drain_data", want.drain_data, rsp.drain_data);
                end
            end
            if (req_valid && !req_stall)
                due_rsp.insert(due_rsp.size(), access_cache(req));
            pending = due_rsp.size();
        end
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import wtcsb_pkg::*;

    localparam int LINES        = 64;
    localparam int BLOCK_BYTES  = 64;
    localparam int BUFFER_DEPTH = 8;
    localparam int OFFSET_W     = $clog2(BLOCK_BYTES);
    localparam int INDEX_W      = $clog2(LINES);
    localparam int TAG_W        = 32 - OFFSET_W - INDEX_W;
    localparam int WORDS        = BLOCK_BYTES / WORD_BYTES;
    localparam int ITEMS        = 1850;
    localparam int PHASE_LEN    = 300;
    localparam int HOLD_LEN     = 200;
    localparam int WATCHDOG     = 2000;
    localparam int POOL         = 8;
    localparam logic [1:0] BURST_ALT = 2'd3;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;
    int   errors;
    int   pending;

    int             sent = 0;
    int             hold_asks = 0;
    bit             tx_busy = 1'b0;
    bit             rx_quiet = 1'b0;
    logic [31:0]    pool [POOL];
    logic [WORDS-1:0] filled [LINES];

    write_through_cache_store_buffer #(
        .LINES       (LINES),
        .BLOCK_BYTES (BLOCK_BYTES),
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    wtcsb_check #(
        .LINES       (LINES),
        .BLOCK_BYTES (BLOCK_BYTES),
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic req_t txn(logic [1:0] act, logic [31:0] base, logic [7:0] idx,
                                 logic [8:0] cnt, logic [1:0] btype, logic [63:0] data,
                                 logic last);
        req_t t;
        t.action       = act;
        t.base_address = base;
        t.beat_index   = idx;
        t.beat_count   = cnt;
        t.burst_type   = btype;
        t.write_data   = data;
        t.fill_last    = last;
        return t;
    endfunction

    function automatic req_t beat_txn(logic [1:0] act);
        logic [8:0] cnt;
        case ($urandom_range(0, 7))
            0:       cnt = 9'd1;
            1:       cnt = 9'd2;
            2:       cnt = 9'd4;
            3:       cnt = 9'd8;
            4:       cnt = 9'd16;
            5:       cnt = 9'd256;
            6:       cnt = 9'($urandom_range(1, 256));
            default: cnt = 9'($urandom);
        endcase
        return txn(act, pool[$urandom_range(0, POOL - 1)] + $urandom_range(0, 63),
                   ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7)),
                   cnt, 2'($urandom), {$urandom, $urandom}, 1'($urandom));
    endfunction

    // a line only turns valid once every word of its slot has been written
    task automatic send(input req_t t);
        int gap;
        int r;
        logic [INDEX_W-1:0] li;
        if (t.action == ACT_FILL)
        begin
            li = t.base_address[OFFSET_W +: INDEX_W];
            if (t.beat_index < WORDS)
                filled[li][t.beat_index] = 1'b1;
            if (!(&filled[li]))
                t.fill_last = 1'b0;
        end
        r = $urandom_range(0, 99);
        if (tx_busy || r < 60)
            gap = 0;
        else if (r < 85)
            gap = $urandom_range(1, 3);
        else if (r < 97)
            gap = $urandom_range(4, 10);
        else
            gap = $urandom_range(15, 40);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= t;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        sent++;
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic random_op();
        int          r;
        logic [31:0] base;
        r = $urandom_range(0, 99);
        if (r < 6)
        begin
            base = ($urandom_range(0, 3) == 0) ? ($urandom & ~32'(BLOCK_BYTES - 1))
                                               : pool[$urandom_range(0, POOL - 1)];
            for (int i = 0; i < WORDS; i++)
                send(txn(ACT_FILL, base, 8'(i), 9'($urandom), 2'($urandom),
                         {$urandom, $urandom}, i == WORDS - 1));
        end
        else if (r < 38)
            send(beat_txn(ACT_READ));
        else if (r < 63)
            send(beat_txn(ACT_WRITE));
        else if (r < 85)
            send(txn(ACT_DRAIN, $urandom, 8'($urandom), 9'($urandom), 2'($urandom),
                     {$urandom, $urandom}, 1'($urandom)));
        else
            send(txn(2'($urandom), $urandom, 8'($urandom), 9'($urandom), 2'($urandom),
                     {$urandom, $urandom}, 1'($urandom)));
    endtask

    // response side backpressure
    initial
    begin
        int len;
        int served;
        int r;
        served    = 0;
        rsp_stall = 1'b0;
        @(posedge clk);
        forever
        begin
            r = $urandom_range(0, 99);
            if (hold_asks != served)
            begin
                served++;
                rsp_stall <= 1'b1;
                len = HOLD_LEN;
            end
            else if (rx_quiet)
            begin
                rsp_stall <= 1'b0;
                len = $urandom_range(1, 20);
            end
            else if (r < 55)
            begin
                rsp_stall <= 1'b0;
                len = $urandom_range(1, 4);
            end
            else if (r < 85)
            begin
                rsp_stall <= 1'b1;
                len = $urandom_range(1, 3);
            end
            else if (r < 95)
            begin
                rsp_stall <= 1'b0;
                len = $urandom_range(10, 40);
            end
            else
            begin
                rsp_stall <= 1'b1;
                len = $urandom_range(15, 50);
            end
            repeat (len) @(posedge clk);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < WATCHDOG)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int               phase;
        int               phase_end;
        logic [TAG_W-1:0] tg;
        logic [INDEX_W-1:0] ln;
        req_valid = 1'b0;
        req       = '0;
        rst_n     = 1'b0;
        foreach (filled[i])
            filled[i] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty drain, misses, address overflow, fill of the top line
        send(txn(ACT_DRAIN, 32'h0, 8'd0, 9'd0, BT_FIXED, 64'h0, 1'b0));
        send(txn(ACT_READ, 32'h0, 8'd0, 9'd1, BT_FIXED, 64'h0, 1'b0));
        send(txn(ACT_READ, 32'hFFFF_FFF8, 8'd1, 9'd2, BT_INCR, '1, 1'b1));
        for (int i = 0; i < WORDS; i++)
            send(txn(ACT_FILL, 32'hFFFF_FFC0, 8'(i), 9'd0, BT_FIXED,
                     (i == 0) ? '1 : (i == 1) ? 64'h0 : {$urandom, $urandom},
                     i == WORDS - 1));
        send(txn(ACT_FILL, 32'hFFFF_FFC0, 8'd200, 9'd0, BT_FIXED, {$urandom, $urandom}, 1'b0));
        send(txn(ACT_READ, 32'hFFFF_FFC5, 8'd0, 9'd1, BT_FIXED, 64'h0, 1'b0));
        send(txn(ACT_READ, 32'hFFFF_FFF0, 8'd3, 9'd4, BT_WRAP, 64'h0, 1'b0));
        send(txn(ACT_READ, 32'hFFFF_FFC0, 8'd1, 9'd3, BT_WRAP, 64'h0, 1'b0));
        send(txn(ACT_READ, 32'h0, 8'd255, 9'd256, BURST_ALT, 64'h0, 1'b0));
        send(txn(ACT_WRITE, 32'hFFFF_FFC0, 8'd0, 9'd1, BT_FIXED, 64'h0123_4567_89AB_CDEF, 1'b0));
        send(txn(ACT_READ, 32'hFFFF_FFC0, 8'd0, 9'd1, BT_FIXED, 64'h0, 1'b0));
        // fill the store buffer up to its last usable slot, then one more
        send(txn(ACT_WRITE, 32'hFFFF_FFC8, 8'd1, 9'd0, BT_WRAP, {$urandom, $urandom}, 1'b0));
        send(txn(ACT_WRITE, 32'h0, 8'd255, 9'd256, BT_WRAP, {$urandom, $urandom}, 1'b0));
        send(txn(ACT_WRITE, 32'hFFFF_FFFF, 8'd0, 9'd1, BT_FIXED, '1, 1'b0));
        send(txn(ACT_WRITE, 32'hFFFF_FC00, 8'd255, 9'd256, BT_INCR, 64'h0, 1'b0));
        send(txn(ACT_WRITE, 32'hFFFF_FFE0, 8'd2, 9'd8, BURST_ALT, {$urandom, $urandom}, 1'b0));
        send(txn(ACT_WRITE, 32'hFFFF_FFC0, 8'd5, 9'd1, BT_WRAP, {$urandom, $urandom}, 1'b0));
        send(txn(ACT_WRITE, 32'hFFFF_FFF8, 8'd0, 9'd1, BT_FIXED, {$urandom, $urandom}, 1'b0));
        send(txn(ACT_READ, 32'hFFFF_FFF8, 8'd0, 9'd1, BT_FIXED, 64'h0, 1'b0));
        send(txn(ACT_DRAIN, 32'h0, 8'd0, 9'd0, BT_FIXED, 64'h0, 1'b0));
        wait_drained();

        phase = 0;
        while (sent < ITEMS)
        begin
            for (int i = 0; i < POOL; i++)
            begin
                case ($urandom_range(0, 3))
                    0:       tg = '0;
                    1:       tg = '1;
                    default: tg = TAG_W'($urandom_range(0, 3));
                endcase
                ln = ($urandom_range(0, 1) == 0) ? '1 : INDEX_W'($urandom_range(0, 3));
                pool[i] = {tg, ln, {OFFSET_W{1'b0}}};
            end
            tx_busy  = (phase % 3 == 1);
            rx_quiet = (phase % 3 == 2);
            if (phase == 1)
                hold_asks <= hold_asks + 1;
            phase_end = sent + PHASE_LEN;
            while (sent < phase_end && sent < ITEMS)
                random_op();
            wait_drained();
            phase++;
        end

        repeat (20) @(posedge clk);
        @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
